### sv/glyph_run_width_and_fit_defines.svh
// Assertion macros for the glyph run width and fit block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef GLYPH_RUN_WIDTH_AND_FIT_DEFINES_SVH
`define GLYPH_RUN_WIDTH_AND_FIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define GWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds.
`define GWF_ASSERT_NEVER(lbl, cond, msg) \
  `GWF_ASSERT(lbl, !(cond), msg)
`else
`define GWF_ASSERT(lbl, prop, msg)
`define GWF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### sv/gwf_pkg.sv
// Shared types, constants and helpers of the glyph run width and fit block.
// No dependencies.
package gwf_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned PROD_W = 34;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_MEASURE = 1'b1
  } func_e;

  typedef enum logic {
    REG_SCALE = 1'b0,
    REG_LIMIT = 1'b1
  } reg_e;

  localparam logic [15:0] SCALE_RESET = 16'd4096;
  localparam logic [46:0] LIMIT_RESET = {47{1'b1}};

  typedef struct packed {
    logic               func;
    logic [20:0]        code_point;
    logic signed [15:0] bearing_x;
    logic signed [15:0] advance;
    logic [14:0]        glyph_w;
    logic               first_char;
    logic               last_char;
  } glyph_in_t;

  typedef struct packed {
    logic signed [47:0] text_width;
    logic [19:0]        fit_bytes;
    logic               overrun;
    logic               last;
  } glyph_out_t;

  // One table entry: scaled-free metrics as loaded.
  typedef struct packed {
    logic signed [15:0] bear;
    logic signed [15:0] adv;
    logic [14:0]        wid;
  } metric_t;

  // Per-character sideband that rides along the pipeline.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [2:0] len;
  } char_ctl_t;

  // Scaled candidates for both bearing rules, ready for the pen recurrence.
  typedef struct packed {
    logic                      valid;
    char_ctl_t                 ctl;
    logic signed [PROD_W-1:0]  neg_bs;
    logic signed [PROD_W-1:0]  adv_a;
    logic signed [PROD_W-1:0]  max_a;
    logic signed [PROD_W-1:0]  adv_b;
    logic signed [PROD_W-1:0]  max_b;
  } cand_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h80) begin
      n = 3'd1;
    end else if (cp < 21'h800) begin
      n = 3'd2;
    end else if (cp < 21'h10000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

### sv/glyph_run_width_and_fit.sv
// Glyph run width and fit: top level with metric table, config registers and pipeline.
// A measure item's result passes the table read, multiply, candidate and result registers; a load gives none.
// Throughput: one item per cycle while no stall holds the flow, set by the pen recurrence in gwf_run_acc.
// Reset: a clearing pass writes zero metrics to all TableEntries table entries, one per
// cycle, with in_stall_o high; config writes are taken throughout.
// Depends on gwf_pkg, gwf_ram, gwf_scale, gwf_run_acc and the defines header.
`include "glyph_run_width_and_fit_defines.svh"

module glyph_run_width_and_fit import gwf_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  glyph_in_t   in_item_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output glyph_out_t  out_item_o,
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output logic [63:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned AW = $clog2(TableEntries);
  localparam logic [AW-1:0] LastIdx = AW'(TableEntries - 1);
  localparam logic [20:0] DepthCp = 21'(TableEntries);

  // Configuration registers.
  logic [15:0] scale_q;
  logic [46:0] limit_q;
  logic        cfg_wr;
  logic        cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign cfg_idx  = paddr_i[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCALE: scale_q <= pwdata_i[15:0];
        REG_LIMIT: limit_q <= pwdata_i[46:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCALE: prdata_o = {48'b0, scale_q};
      REG_LIMIT: prdata_o = {17'b0, limit_q};
      default:   prdata_o = '0;
    endcase
  end

  // Clearing pass after reset: sweep the table once, writing zero metrics.
  logic          clearing_q, clearing_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      if (clr_addr_q == LastIdx) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Accept logic. Loads write the table at the accept edge and measures read it at
  // theirs, so a measure always sees every earlier load: no forwarding is needed.
  logic      accept, is_measure, is_load, in_range;
  logic      s1_take, s1_ready;
  logic      s1_v_q;
  char_ctl_t s1_ctl_q, s1_ctl_d;
  logic      s1_rng_q;
  logic      ram_we, ram_re;
  logic [AW-1:0] ram_waddr, idx;
  metric_t   ram_wdata, ram_rdata, s1_metric;

  assign s1_ready   = !s1_v_q || s1_take;
  assign in_stall_o = clearing_q || !s1_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_measure = in_item_i.func == FUNC_MEASURE;
  assign is_load    = in_item_i.func == FUNC_LOAD;
  assign in_range   = in_item_i.code_point < DepthCp;
  assign idx        = in_item_i.code_point[AW-1:0];

  always_comb begin
    ram_we    = clearing_q || (accept && is_load && in_range);
    ram_waddr = clearing_q ? clr_addr_q : idx;
    ram_wdata = '0;
    if (!clearing_q) begin
      ram_wdata.bear = in_item_i.bearing_x;
      ram_wdata.adv  = in_item_i.advance;
      ram_wdata.wid  = in_item_i.glyph_w;
    end
    ram_re = accept && is_measure;

    s1_ctl_d.first = in_item_i.first_char;
    s1_ctl_d.last  = in_item_i.last_char;
    s1_ctl_d.len   = utf8_len(in_item_i.code_point);
  end

  gwf_ram #(
    .Width ($bits(metric_t)),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  // Read stage: the table output register holds the metrics while this stage waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (ram_re) begin
      s1_v_q <= 1'b1;
    end else if (s1_take) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_ctl_q <= s1_ctl_d;
      s1_rng_q <= in_range;
    end
  end

  // Code points beyond the table measure with zero metrics.
  assign s1_metric = s1_rng_q ? ram_rdata : '0;

  cand_t cand;
  logic  acc_ready;

  gwf_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_v_q),
    .ctl_i       (s1_ctl_q),
    .metric_i    (s1_metric),
    .scale_i     (scale_q),
    .take_o      (s1_take),
    .acc_ready_i (acc_ready),
    .cand_o      (cand)
  );

  gwf_run_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cand_i      (cand),
    .limit_i     (limit_q),
    .ready_o     (acc_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A measure accepted always lands in the read stage.
  `GWF_ASSERT(a_measure_lands, ram_re |=> s1_v_q, "accepted measure item lost")
  // A new read never overwrites metrics that the read stage still holds.
  `GWF_ASSERT_NEVER(a_read_clobber, s1_v_q && !s1_take && ram_re, "table read clobbered")
  // The clearing pass ends only after the last table entry.
  `GWF_ASSERT(a_clear_done, $fell(clearing_q) |-> $past(clr_addr_q) == LastIdx, "short clear")

endmodule

### sv/gwf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gwf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gwf_scale.sv
// Scale stages: multiply the metrics by the scale, then form both bearing-rule candidates.
// Depends on gwf_pkg.
module gwf_scale import gwf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  char_ctl_t   ctl_i,
  input  metric_t     metric_i,
  input  logic [15:0] scale_i,
  output logic        take_o,
  input  logic        acc_ready_i,
  output cand_t       cand_o
);

  logic                      s2_v_q;
  char_ctl_t                 s2_ctl_q;
  logic signed [32:0]        bs_q, as_q, ws_q;
  logic signed [32:0]        bs_d, as_d, ws_d;
  logic signed [16:0]        sc_s;
  logic                      s3_v_q;
  cand_t                     s3_q, s3_d;
  logic                      s3_take;
  logic signed [PROD_W-1:0]  bs_x, as_x, ws_x, ext_b;

  assign s3_take = !s3_v_q || acc_ready_i;
  assign take_o  = !s2_v_q || s3_take;

  // Multiply stage.
  always_comb begin
    sc_s = $signed({1'b0, scale_i});
    bs_d = 33'(metric_i.bear) * 33'(sc_s);
    as_d = 33'(metric_i.adv) * 33'(sc_s);
    ws_d = 33'($signed({1'b0, metric_i.wid})) * 33'(sc_s);
  end

  // Candidate stage.
  always_comb begin
    bs_x  = {bs_q[32], bs_q};
    as_x  = {as_q[32], as_q};
    ws_x  = {ws_q[32], ws_q};
    ext_b = ws_x + bs_x;
    s3_d.valid  = 1'b1;
    s3_d.ctl    = s2_ctl_q;
    s3_d.neg_bs = -bs_x;
    s3_d.adv_a  = as_x - bs_x;
    s3_d.max_a  = (s3_d.adv_a > ws_x) ? s3_d.adv_a : ws_x;
    s3_d.adv_b  = as_x;
    s3_d.max_b  = (as_x > ext_b) ? as_x : ext_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (take_o) begin
        s2_v_q <= valid_i;
      end
      if (s3_take) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      s2_ctl_q <= ctl_i;
      bs_q     <= bs_d;
      as_q     <= as_d;
      ws_q     <= ws_d;
    end
    if (s3_take && s2_v_q) begin
      s3_q <= s3_d;
    end
  end

  always_comb begin
    cand_o       = s3_q;
    cand_o.valid = s3_v_q;
  end

endmodule

### sv/gwf_run_acc.sv
// Pen recurrence: rule choice, running width, fit byte count, overrun flag, result register.
// Depends on gwf_pkg.
module gwf_run_acc import gwf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cand_t       cand_i,
  input  logic [46:0] limit_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output glyph_out_t  out_item_o
);

  localparam logic signed [47:0] WMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] WMin = {1'b1, {47{1'b0}}};

  logic signed [47:0] pen_q, pen_d, pen_e;
  logic [19:0]        cnt_q, cnt_d, cnt_e;
  logic               ov_q, ov_d, ov_e;
  logic               out_v_q;
  glyph_out_t         out_q, out_d;
  logic               step;
  logic               rule_a;
  logic signed [47:0] neg_bs_x, tw;
  logic signed [PROD_W-1:0] adv_sel, max_sel;
  logic [20:0]        cnt_sum;

  function automatic logic signed [47:0] add_sat(input logic signed [47:0] a,
                                                 input logic signed [PROD_W-1:0] b);
    logic signed [48:0] s;
    logic signed [47:0] r;
    s = {a[47], a} + {{(49-PROD_W){b[PROD_W-1]}}, b};
    if (s[48] != s[47]) begin
      r = s[48] ? WMin : WMax;
    end else begin
      r = s[47:0];
    end
    return r;
  endfunction

  assign ready_o = !out_v_q || !out_stall_i;
  assign step    = cand_i.valid && ready_o;

  always_comb begin
    // A first character starts the string from a clean pen.
    pen_e = cand_i.ctl.first ? '0 : pen_q;
    cnt_e = cand_i.ctl.first ? '0 : cnt_q;
    ov_e  = cand_i.ctl.first ? 1'b0 : ov_q;

    neg_bs_x = {{(48-PROD_W){cand_i.neg_bs[PROD_W-1]}}, cand_i.neg_bs};
    rule_a   = pen_e < neg_bs_x;
    adv_sel  = rule_a ? cand_i.adv_a : cand_i.adv_b;
    max_sel  = rule_a ? cand_i.max_a : cand_i.max_b;

    tw    = add_sat(pen_e, max_sel);
    pen_d = add_sat(pen_e, adv_sel);

    ov_d    = ov_e || (tw > $signed({1'b0, limit_i}));
    cnt_sum = {1'b0, cnt_e} + {18'b0, cand_i.ctl.len};
    if (ov_d) begin
      cnt_d = cnt_e;
    end else if (cnt_sum[20]) begin
      cnt_d = '1;
    end else begin
      cnt_d = cnt_sum[19:0];
    end

    out_d.text_width = tw;
    out_d.fit_bytes  = cnt_d;
    out_d.overrun    = ov_d;
    out_d.last       = cand_i.ctl.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ready_o) begin
        out_v_q <= cand_i.valid;
      end
      if (step) begin
        pen_q <= pen_d;
        cnt_q <= cnt_d;
        ov_q  <= ov_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

### tb/tb_top.sv
// Self-checking bench for glyph_run_width_and_fit: table loads, string measures, scale/limit.
// Holds its own model of the metric table, the pen and the fit counter, and checks every result.
// Depends on gwf_pkg and the glyph_run_width_and_fit RTL.
`timescale 1ns / 1ps

module tb_top;
  import gwf_pkg::*;

  // Q35.12 pen range, saturating bounds
  localparam longint PEN_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PEN_MIN = -64'sh0000_8000_0000_0000;
  localparam logic [46:0] LIMIT_MAX = {47{1'b1}};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  glyph_in_t   in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  glyph_out_t  out_item_o;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [3:0]  paddr_i = '0;
  logic [63:0] pwdata_i = '0;
  logic [63:0] prdata_o;
  logic        pready_o;

  glyph_run_width_and_fit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel_i      (psel_i),
    .penable_i   (penable_i),
    .pwrite_i    (pwrite_i),
    .paddr_i     (paddr_i),
    .pwdata_i    (pwdata_i),
    .prdata_o    (prdata_o),
    .pready_o    (pready_o)
  );

  // Model state: metric table (cleared like the block after reset), pen, fit counter
  bit                 glyph_known [TABLE_ENTRIES];
  logic signed [15:0] glyph_bear  [TABLE_ENTRIES];
  logic signed [15:0] glyph_adv   [TABLE_ENTRIES];
  logic [14:0]        glyph_wid   [TABLE_ENTRIES];
  longint             pen_pos = 0;
  int unsigned        fit_count = 0;
  bit                 overrun_flag = 1'b0;
  longint             scale_now = longint'(SCALE_RESET);
  longint             limit_now = longint'(LIMIT_RESET);

  glyph_in_t  pending_items_q[$];   // items waiting to be offered
  glyph_out_t run_widths_q[$];      // predicted run results, oldest first

  bit calm = 1'b0;                  // no idling on either side
  int send_gap = 0;
  int stall_gap = 0;
  int hold_left = 0;
  int rx_seen = 0;
  int items_taken = 0;
  int loads_stored = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int fails = 0;

  initial begin
    foreach (glyph_known[i]) begin
      glyph_known[i] = 1'b0;
      glyph_bear[i] = '0;
      glyph_adv[i] = '0;
      glyph_wid[i] = '0;
    end
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp48(input longint v);
    if (v > PEN_MAX) return PEN_MAX;
    if (v < PEN_MIN) return PEN_MIN;
    return v;
  endfunction

  // UTF-8 length from the highest occupied bit range of the code point
  function automatic int unsigned utf8_bytes(input logic [20:0] cp);
    if (cp[20:16] != '0) return 4;
    if (cp[15:11] != '0) return 3;
    if (cp[10:7] != '0) return 2;
    return 1;
  endfunction

  // Apply one accepted item: store a load, or measure a character and queue its result
  function automatic void advance_pen(input glyph_in_t it);
    longint bx, aw, w, sc, adv_s, ext_s, tw;
    int unsigned n;
    glyph_out_t r;
    bx = 0;
    aw = 0;
    w = 0;
    if (it.func == FUNC_LOAD) begin
      // loads beyond the table are dropped; flags mean nothing here
      if ({11'b0, it.code_point} < TABLE_ENTRIES) begin
        glyph_known[it.code_point[9:0]] = 1'b1;
        glyph_bear[it.code_point[9:0]] = it.bearing_x;
        glyph_adv[it.code_point[9:0]] = it.advance;
        glyph_wid[it.code_point[9:0]] = it.glyph_w;
        loads_stored++;
      end
      return;
    end
    if (it.first_char) begin
      pen_pos = 0;
      fit_count = 0;
      overrun_flag = 1'b0;
    end
    // absent glyphs and code points past the table measure as zero metrics
    if ({11'b0, it.code_point} < TABLE_ENTRIES && glyph_known[it.code_point[9:0]]) begin
      bx = longint'(glyph_bear[it.code_point[9:0]]);
      aw = longint'(glyph_adv[it.code_point[9:0]]);
      w = longint'(glyph_wid[it.code_point[9:0]]);
    end
    sc = scale_now;
    // pick the bearing rule from the pen against the negated scaled bearing
    if (pen_pos < -bx * sc) begin
      adv_s = (aw - bx) * sc;
      ext_s = w * sc;
    end else begin
      adv_s = aw * sc;
      ext_s = (w + bx) * sc;
    end
    tw = clamp48(pen_pos + ((adv_s > ext_s) ? adv_s : ext_s));
    pen_pos = clamp48(pen_pos + adv_s);
    if (tw > limit_now) overrun_flag = 1'b1;
    // once over the limit, no character of this string adds bytes
    if (!overrun_flag) begin
      n = fit_count + utf8_bytes(it.code_point);
      fit_count = (n > 32'hF_FFFF) ? 32'hF_FFFF : n;
    end
    r.text_width = tw[47:0];
    r.fit_bytes = fit_count[19:0];
    r.overrun = overrun_flag;
    r.last = it.last_char;
    run_widths_q.push_back(r);
  endfunction

  // Driver: hold a stalled item, otherwise idle in bursts or advance to the next item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        advance_pen(in_item_i);
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else if (pending_items_q.size() != 0) begin
          in_item_i <= pending_items_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus two long hold-offs so the pipeline backs up
  // and the block has to stall its input while the driver keeps offering items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        rx_seen++;
        if (rx_seen == 150 || rx_seen == 450) hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin : monitor
    glyph_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (run_widths_q.size() == 0) begin
        $error("result with nothing pending: text_width %0d", out_item_o.text_width);
        fails++;
      end else begin
        want = run_widths_q.pop_front();
        results_checked++;
        if (out_item_o.text_width !== want.text_width) begin
          $error("text_width: expected %0d, got %0d", want.text_width, out_item_o.text_width);
          fails++;
        end
        if (out_item_o.fit_bytes !== want.fit_bytes) begin
          $error("fit_bytes: expected %0d, got %0d", want.fit_bytes, out_item_o.fit_bytes);
          fails++;
        end
        if (out_item_o.overrun !== want.overrun) begin
          $error("overrun: expected %0b, got %0b", want.overrun, out_item_o.overrun);
          fails++;
        end
        if (out_item_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_item_o.last);
          fails++;
        end
      end
    end
  end

  task automatic push_item(input logic fn, input logic [20:0] cp, input logic [15:0] bear,
                           input logic [15:0] adv, input logic [14:0] wid,
                           input logic first, input logic last);
    glyph_in_t it;
    it.func = fn;
    it.code_point = cp;
    it.bearing_x = bear;
    it.advance = adv;
    it.glyph_w = wid;
    it.first_char = first;
    it.last_char = last;
    pending_items_q.push_back(it);
  endtask

  // Metric value, leaning on the signed and unsigned extremes
  function automatic logic [15:0] pick16();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      default: ;
    endcase
    return v;
  endfunction

  // Code point: mostly a small hot set so measures hit loaded glyphs,
  // the rest spread over every UTF-8 length and the full field width
  function automatic logic [20:0] pick_cp();
    logic [20:0] cp;
    case ($urandom_range(0, 9))
      0: cp = 21'($urandom_range(0, 21'h1F_FFFF));
      1: cp = 21'($urandom_range(0, 21'h00_FFFF));
      2: cp = 21'($urandom_range(0, 21'h00_07FF));
      3, 4: cp = 21'($urandom_range(0, TABLE_ENTRIES - 1));
      default: cp = 21'($urandom_range(0, 63));
    endcase
    return cp;
  endfunction

  // Random phase: loads, well-formed strings, and some stray or broken measures
  task automatic build_phase(input int n);
    int made, len, k;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          push_item(FUNC_LOAD, pick_cp(), pick16(), pick16(), 15'(pick16() >> 1),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          made++;
        end
        9: begin
          // stray measure: flags at random, so strings may start or end mid-run
          push_item(FUNC_MEASURE, pick_cp(), pick16(), pick16(), 15'(pick16() >> 1),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          made++;
        end
        default: begin
          len = $urandom_range(1, 12);
          for (k = 0; k < len; k++) begin
            push_item(FUNC_MEASURE, pick_cp(), pick16(), pick16(), 15'(pick16() >> 1),
                      k == 0, k == len - 1);
          end
          made += len;
        end
      endcase
    end
  endtask

  // Register write: setup then access; the write lands when pready is seen high
  task automatic set_reg(input reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= {idx, 3'b000};
    pwdata_i <= val;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    case (idx)
      REG_SCALE: scale_now = longint'(val[15:0]);
      REG_LIMIT: limit_now = longint'(val[46:0]);
      default: ;
    endcase
    reg_writes++;
  endtask

  // Wait until every item is taken and every result checked, then let the pipe empty
  task automatic settle();
    do @(negedge clk_i);
    while (pending_items_q.size() != 0 || in_valid_i || run_widths_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int p;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: loads at the table edges, ignored loads past the table,
    // then one string over every UTF-8 length, absent glyphs and both bearing rules
    push_item(FUNC_LOAD, 21'd0, 16'h8000, 16'h7FFF, 15'h7FFF, 1'b1, 1'b1);
    push_item(FUNC_LOAD, 21'd1023, 16'h7FFF, 16'h8000, 15'h0000, 1'b0, 1'b0);
    push_item(FUNC_LOAD, 21'h41, 16'd16, 16'd160, 15'd128, 1'b0, 1'b1);
    push_item(FUNC_LOAD, 21'd1024, 16'd100, 16'd100, 15'd100, 1'b1, 1'b0);
    push_item(FUNC_LOAD, 21'h1F_FFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1, 1'b1);
    push_item(FUNC_MEASURE, 21'd0, '0, '0, '0, 1'b1, 1'b0);
    push_item(FUNC_MEASURE, 21'd1023, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h41, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'd1024, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h7F, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h80, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h7FF, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h800, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'hD800, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'hFFFF, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h1_0000, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h10_FFFF, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h1F_FFFF, '0, '0, '0, 1'b0, 1'b1);
    push_item(FUNC_MEASURE, 21'd0, '0, '0, '0, 1'b0, 1'b0);
    push_item(FUNC_MEASURE, 21'h41, 16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1, 1'b1);
    settle();

    // Random phases, each under its own scale and limit; the last one runs without idling
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin
          set_reg(REG_SCALE, 64'd65535);
          set_reg(REG_LIMIT, 64'(LIMIT_MAX));
        end
        1: begin
          set_reg(REG_SCALE, 64'd0);
          set_reg(REG_LIMIT, 64'($urandom_range(0, 32'h3FFF_FFFF)));
        end
        2: begin
          set_reg(REG_SCALE, 64'($urandom_range(0, 16'hFFFF)));
          set_reg(REG_LIMIT, 64'd0);
        end
        3: begin
          set_reg(REG_SCALE, 64'd4096);
          set_reg(REG_LIMIT, 64'($urandom_range(0, 32'h3FFF_FFFF)));
        end
        4: begin
          set_reg(REG_SCALE, 64'($urandom_range(0, 16'hFFFF)));
          set_reg(REG_LIMIT, 64'($urandom_range(0, 32'h3FFF_FFFF)));
        end
        5: begin
          set_reg(REG_SCALE, 64'd1);
          set_reg(REG_LIMIT, 64'(LIMIT_MAX));
        end
        6: begin
          set_reg(REG_SCALE, 64'($urandom_range(0, 16'hFFFF)));
          set_reg(REG_LIMIT, {$urandom, $urandom} & 64'(LIMIT_MAX));
        end
        default: begin
          set_reg(REG_SCALE, 64'd65535);
          set_reg(REG_LIMIT, 64'($urandom_range(0, 32'h3FFF_FFFF)));
        end
      endcase
      @(negedge clk_i);
      calm = (p == 7);
      build_phase(115);
      settle();
    end

    repeat (10) @(negedge clk_i);
    if (run_widths_q.size() != 0) begin
      $error("%0d predicted results never arrived", run_widths_q.size());
      fails++;
    end
    $display("Run covered %0d items (%0d table loads kept), %0d results checked,",
             items_taken, loads_stored, results_checked);
    $display("across %0d register writes spanning zero, unit and full scale and limits.",
             reg_writes);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, clearing pass and hold-offs included
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
